// ===== hw/rtl/pmt_pkg.sv =====
package pmt_pkg;

    localparam int POS_W      = 12;
    localparam int BOUND_W    = 13;
    localparam int QUO_W      = 8;
    localparam int DIVIDEND_W = POS_W + QUO_W;
    localparam int DSH_W      = BOUND_W + QUO_W - 1;
    localparam int CNT_W      = $clog2(QUO_W);

    localparam logic [QUO_W-1:0] TEXT_COLS = 8'd80;
    localparam logic [QUO_W-1:0] TEXT_ROWS = 8'd25;

    localparam logic [BOUND_W-1:0] BOUND_MAX    = 13'd4096;
    localparam logic [BOUND_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [BOUND_W-1:0] RESET_HEIGHT = 13'd400;
    localparam logic [POS_W-1:0]   RESET_POS_X  = 12'd320;
    localparam logic [POS_W-1:0]   RESET_POS_Y  = 12'd200;

    // wheel modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_BYTE   = 2'd1;
    localparam logic [1:0] MODE_NIBBLE = 2'd2;

    // register indexes
    localparam logic [1:0] REG_WHEEL_MODE    = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

    // header byte bits
    localparam int HDR_SYNC_BIT = 3;
    localparam int HDR_XSGN_BIT = 4;
    localparam int HDR_YSGN_BIT = 5;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_res_t;

    // zero acts as one, anything past the maximum acts as the maximum
    function automatic logic [BOUND_W-1:0] bound_of(input logic [BOUND_W-1:0] r);
        logic [BOUND_W-1:0] b;
        b = r;
        if (r == '0)
        begin
            b = {{(BOUND_W-1){1'b0}}, 1'b1};
        end
        else if (r > BOUND_MAX)
        begin
            b = BOUND_MAX;
        end
        return b;
    endfunction

    function automatic logic [QUO_W-1:0] clamp_quo(input logic [QUO_W-1:0] q,
                                                   input logic [QUO_W-1:0] lim);
        return (q >= lim) ? lim - 8'd1 : q;
    endfunction

endpackage

// ===== hw/rtl/pmt_div.sv =====
module pmt_div import pmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [BOUND_W-1:0]    divisor,
    output div_res_t              res
);

    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DSH_W-1:0]      dsh_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  ge;

    // restoring division, one quotient bit per cycle, MSB first
    assign ge = rem_reg >= DIVIDEND_W'(dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // one-cycle pulse after the last quotient bit
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(QUO_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= {divisor, {(QUO_W-1){1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - DIVIDEND_W'(dsh_reg);
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;

endmodule

// ===== hw/rtl/ps2_mouse_packet_tracker_top.sv =====
// PS/2 mouse packet tracker. Bytes enter one per item on rx_byte; a packet starts only on
// a byte with bit 3 set and bits 7:6 clear, and is three bytes long (wheel_mode 0 or 3)
// or four (modes 1 and 2). Bytes that do not end a packet are taken with in_ready left high.
// The last byte of a packet keeps in_ready low until its result is loaded: the text cell is
// found by one serial restoring divider, shared between column and row, giving one
// quotient bit per cycle, first for the column and then for the row. One result item
// is produced per packet and held in an output register, so bytes keep flowing while it
// waits; a following packet end waits for that register to drain. Write configuration
// only while no packet is being finished; a bound change applies at the next packet.
module ps2_mouse_packet_tracker_top import pmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [11:0]        cursor_x,
    output logic [11:0]        cursor_y,
    output logic [6:0]         text_col,
    output logic [4:0]         text_row,
    output logic signed [8:0]  move_x,
    output logic signed [9:0]  move_y,
    output logic signed [4:0]  wheel_step,
    output logic signed [31:0] scroll_total,
    output logic [2:0]         button_bits,
    output logic [31:0]        packet_total
);

    typedef enum logic [2:0] {ST_IDLE, ST_START, ST_COL_WAIT, ST_ROW_WAIT, ST_LOAD} state_t;
    typedef enum logic [1:0] {PH_HEAD, PH_DX, PH_DY, PH_WHEEL} phase_t;

    state_t             state_reg;
    phase_t             phase_reg;
    logic [1:0]         mode_reg;
    logic [BOUND_W-1:0] width_reg;
    logic [BOUND_W-1:0] height_reg;
    logic [7:0]         pb0_reg;
    logic [7:0]         pb1_reg;
    logic [7:0]         pb2_reg;
    logic [POS_W-1:0]   pos_x_reg;
    logic [POS_W-1:0]   pos_y_reg;
    logic [31:0]        wsum_reg;
    logic [31:0]        tally_reg;
    logic signed [8:0]  mvx_reg;
    logic signed [9:0]  mvy_reg;
    logic signed [4:0]  step_reg;
    logic [2:0]         btn_reg;
    logic [QUO_W-1:0]   col_reg;
    logic               out_valid_reg;

    logic [11:0]        cx_reg;
    logic [11:0]        cy_reg;
    logic [6:0]         tcol_reg;
    logic [4:0]         trow_reg;
    logic signed [8:0]  ox_reg;
    logic signed [9:0]  oy_reg;
    logic signed [4:0]  ostep_reg;
    logic signed [31:0] osum_reg;
    logic [2:0]         obtn_reg;
    logic [31:0]        otally_reg;

    logic               take;
    logic               four_mode;
    logic               last_byte;
    logic               hdr_ok;
    logic [7:0]         dy_byte;
    logic signed [8:0]  dx_s;
    logic signed [8:0]  raw_dy;
    logic signed [9:0]  mvy_s;
    logic signed [13:0] x_sum;
    logic signed [13:0] y_sum;
    logic [BOUND_W-1:0] w_b;
    logic [BOUND_W-1:0] h_b;
    logic [POS_W-1:0]   x_new;
    logic [POS_W-1:0]   y_new;
    logic signed [7:0]  z8;
    logic signed [4:0]  nib5;
    logic signed [4:0]  dz;
    logic signed [4:0]  step_s;
    logic               out_free;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [BOUND_W-1:0]    div_divisor;
    div_res_t              div_res;

    assign in_ready  = (state_reg == ST_IDLE);
    assign take      = in_valid && in_ready;
    assign four_mode = (mode_reg == MODE_BYTE) || (mode_reg == MODE_NIBBLE);
    assign last_byte = (phase_reg == PH_WHEEL) || ((phase_reg == PH_DY) && !four_mode);
    assign hdr_ok    = rx_byte[HDR_SYNC_BIT] && (rx_byte[7:6] == 2'b00);
    assign out_free  = !out_valid_reg || out_ready;

    assign w_b = bound_of(width_reg);
    assign h_b = bound_of(height_reg);

    // deltas; on a three-byte packet the Y byte is the current one
    assign dy_byte = (phase_reg == PH_DY) ? rx_byte : pb2_reg;
    assign dx_s    = $signed({pb0_reg[HDR_XSGN_BIT], pb1_reg});
    assign raw_dy  = $signed({pb0_reg[HDR_YSGN_BIT], dy_byte});
    assign mvy_s   = 10'sd0 - $signed({raw_dy[8], raw_dy});

    assign x_sum = $signed({2'b00, pos_x_reg}) + $signed({{5{dx_s[8]}}, dx_s});
    assign y_sum = $signed({2'b00, pos_y_reg}) + $signed({{4{mvy_s[9]}}, mvy_s});

    always_comb
    begin
        if (x_sum[13])
        begin
            x_new = '0;
        end
        else if (x_sum[12:0] >= w_b)
        begin
            x_new = POS_W'(w_b - 13'd1);
        end
        else
        begin
            x_new = x_sum[11:0];
        end

        if (y_sum[13])
        begin
            y_new = '0;
        end
        else if (y_sum[12:0] >= h_b)
        begin
            y_new = POS_W'(h_b - 13'd1);
        end
        else
        begin
            y_new = y_sum[11:0];
        end
    end

    // wheel: byte mode uses the signed byte when it is within -8..8, else the nibble
    assign z8   = $signed(rx_byte);
    assign nib5 = $signed({rx_byte[3], rx_byte[3:0]});

    always_comb
    begin
        dz = 5'sd0;
        if (phase_reg == PH_WHEEL)
        begin
            case (mode_reg)
                MODE_NIBBLE: dz = nib5;
                MODE_BYTE:   dz = (z8 >= -8'sd8 && z8 <= 8'sd8) ? z8[4:0] : nib5;
                default:     dz = 5'sd0;
            endcase
        end
    end

    assign step_s = 5'sd0 - dz;

    // column goes first, row starts the cycle the column quotient is ready
    assign div_start    = (state_reg == ST_START) || ((state_reg == ST_COL_WAIT) && div_res.done);
    assign div_dividend = (state_reg == ST_START)
                        ? DIVIDEND_W'(pos_x_reg) * DIVIDEND_W'(TEXT_COLS)
                        : DIVIDEND_W'(pos_y_reg) * DIVIDEND_W'(TEXT_ROWS);
    assign div_divisor  = (state_reg == ST_START) ? w_b : h_b;

    pmt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_HEAD;
            mode_reg      <= MODE_NONE;
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
            pb0_reg       <= '0;
            pb1_reg       <= '0;
            pb2_reg       <= '0;
            pos_x_reg     <= RESET_POS_X;
            pos_y_reg     <= RESET_POS_Y;
            wsum_reg      <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WHEEL_MODE:    mode_reg   <= cfg_data[1:0];
                    REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default:           ;
                endcase
            end

            // a new item replaces one leaving in the same cycle
            if ((state_reg == ST_LOAD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        case (phase_reg)
                            PH_HEAD:
                            begin
                                if (hdr_ok)
                                begin
                                    pb0_reg   <= rx_byte;
                                    phase_reg <= PH_DX;
                                end
                            end
                            PH_DX:
                            begin
                                pb1_reg   <= rx_byte;
                                phase_reg <= PH_DY;
                            end
                            PH_DY:
                            begin
                                pb2_reg   <= rx_byte;
                                phase_reg <= four_mode ? PH_WHEEL : PH_HEAD;
                            end
                            default:
                            begin
                                phase_reg <= PH_HEAD;
                            end
                        endcase

                        if (last_byte)
                        begin
                            pos_x_reg <= x_new;
                            pos_y_reg <= y_new;
                            wsum_reg  <= wsum_reg + {{27{step_s[4]}}, step_s};
                            tally_reg <= tally_reg + 32'd1;
                            state_reg <= ST_START;
                        end
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_COL_WAIT;
                end
                ST_COL_WAIT:
                begin
                    if (div_res.done)
                    begin
                        state_reg <= ST_ROW_WAIT;
                    end
                end
                ST_ROW_WAIT:
                begin
                    if (div_res.done)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take && last_byte)
        begin
            mvx_reg  <= dx_s;
            mvy_reg  <= mvy_s;
            step_reg <= step_s;
            btn_reg  <= pb0_reg[2:0];
        end
        if ((state_reg == ST_COL_WAIT) && div_res.done)
        begin
            col_reg <= clamp_quo(div_res.quo, TEXT_COLS);
        end
        if ((state_reg == ST_LOAD) && out_free)
        begin
            cx_reg     <= pos_x_reg;
            cy_reg     <= pos_y_reg;
            tcol_reg   <= col_reg[6:0];
            trow_reg   <= 5'(clamp_quo(div_res.quo, TEXT_ROWS));
            ox_reg     <= mvx_reg;
            oy_reg     <= mvy_reg;
            ostep_reg  <= step_reg;
            osum_reg   <= $signed(wsum_reg);
            obtn_reg   <= btn_reg;
            otally_reg <= tally_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_x     = cx_reg;
    assign cursor_y     = cy_reg;
    assign text_col     = tcol_reg;
    assign text_row     = trow_reg;
    assign move_x       = ox_reg;
    assign move_y       = oy_reg;
    assign wheel_step   = ostep_reg;
    assign scroll_total = osum_reg;
    assign button_bits  = obtn_reg;
    assign packet_total = otally_reg;

`ifndef SYNTH
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, text_col} < TEXT_COLS))
        else $error("text column out of range");

    a_cursor_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, cursor_x} < w_b) && ({1'b0, cursor_y} < h_b))
        else $error("cursor outside screen bounds");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_COL_WAIT) || (state_reg == ST_ROW_WAIT))
        else $error("divider finished outside a wait state");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && last_byte |=> !in_ready && (tally_reg == $past(tally_reg) + 32'd1))
        else $error("packet end not handled");
`endif

endmodule

// ===== test/ps2_mouse_packet_tracker_top_test.sv =====
`timescale 1ns / 100ps

import pmt_pkg::*;

typedef struct packed {
    logic [11:0] cursor_x;
    logic [11:0] cursor_y;
    logic [6:0]  text_col;
    logic [4:0]  text_row;
    logic [8:0]  move_x;
    logic [9:0]  move_y;
    logic [4:0]  wheel_step;
    logic [31:0] scroll_total;
    logic [2:0]  button_bits;
    logic [31:0] packet_total;
} mouse_report_t;

// Tracks packet framing and cursor state, queues the report each packet should produce.
class mouse_report_board;
    logic [1:0]    wheel_mode;
    logic [12:0]   width_reg;
    logic [12:0]   height_reg;
    logic [1:0]    phase;
    logic [7:0]    hdr;
    logic [7:0]    x_byte;
    logic [7:0]    y_byte;
    int            pos_x;
    int            pos_y;
    logic [31:0]   scroll_sum;
    logic [31:0]   packet_count;
    mouse_report_t expected_q[$];
    int            errors;
    int            reports_seen;

    function new();
        wheel_mode   = MODE_NONE;
        width_reg    = RESET_WIDTH;
        height_reg   = RESET_HEIGHT;
        phase        = 2'd0;
        hdr          = 8'd0;
        x_byte       = 8'd0;
        y_byte       = 8'd0;
        pos_x        = int'(RESET_POS_X);
        pos_y        = int'(RESET_POS_Y);
        scroll_sum   = 32'd0;
        packet_count = 32'd0;
        errors       = 0;
        reports_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [12:0] val);
        if (idx == REG_WHEEL_MODE)
        begin
            wheel_mode = val[1:0];
        end
        else if (idx == REG_SCREEN_WIDTH)
        begin
            width_reg = val;
        end
        else if (idx == REG_SCREEN_HEIGHT)
        begin
            height_reg = val;
        end
    endfunction

    function bit four_byte_mode();
        return wheel_mode == MODE_BYTE || wheel_mode == MODE_NIBBLE;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function int clip_bound(logic [12:0] r);
        if (r == 13'd0)
        begin
            return 1;
        end
        if (r > 13'd4096)
        begin
            return 4096;
        end
        return int'(r);
    endfunction

    function void close_packet(logic [7:0] last, bit four);
        mouse_report_t r;
        int dx, dy, dz, z, nib, w, h, col, row;
        dx = x_byte;
        if (hdr[4])
        begin
            dx -= 256;
        end
        dy = y_byte;
        if (hdr[5])
        begin
            dy -= 256;
        end
        dz = 0;
        // mode is sampled when the packet closes, not when it started
        if (four && four_byte_mode())
        begin
            nib = last[3:0];
            if (last[3])
            begin
                nib -= 16;
            end
            z = last;
            if (z >= 128)
            begin
                z -= 256;
            end
            if (wheel_mode == MODE_BYTE && z >= -8 && z <= 8)
            begin
                dz = -z;
            end
            else
            begin
                dz = -nib;
            end
        end
        scroll_sum   = scroll_sum + dz;
        packet_count = packet_count + 1;
        w = clip_bound(width_reg);
        h = clip_bound(height_reg);
        pos_x = pos_x + dx;
        if (pos_x < 0)
        begin
            pos_x = 0;
        end
        else if (pos_x >= w)
        begin
            pos_x = w - 1;
        end
        pos_y = pos_y - dy;
        if (pos_y < 0)
        begin
            pos_y = 0;
        end
        else if (pos_y >= h)
        begin
            pos_y = h - 1;
        end
        col = pos_x * int'(TEXT_COLS) / w;
        row = pos_y * int'(TEXT_ROWS) / h;
        if (col >= int'(TEXT_COLS))
        begin
            col = int'(TEXT_COLS) - 1;
        end
        if (row >= int'(TEXT_ROWS))
        begin
            row = int'(TEXT_ROWS) - 1;
        end
        r.cursor_x     = 12'(pos_x);
        r.cursor_y     = 12'(pos_y);
        r.text_col     = 7'(col);
        r.text_row     = 5'(row);
        r.move_x       = 9'(dx);
        r.move_y       = 10'(-dy);
        r.wheel_step   = 5'(dz);
        r.scroll_total = scroll_sum;
        r.button_bits  = hdr[2:0];
        r.packet_total = packet_count;
        expected_q.push_back(r);
    endfunction

    // returns 1 when the byte was used, 0 when dropped while hunting for a header
    function bit note_byte(logic [7:0] b);
        case (phase)
            2'd0:
            begin
                if (!b[3] || b[7:6] != 2'b00)
                begin
                    return 1'b0;
                end
                hdr   = b;
                phase = 2'd1;
            end
            2'd1:
            begin
                x_byte = b;
                phase  = 2'd2;
            end
            2'd2:
            begin
                y_byte = b;
                if (four_byte_mode())
                begin
                    phase = 2'd3;
                end
                else
                begin
                    phase = 2'd0;
                    close_packet(8'd0, 1'b0);
                end
            end
            default:
            begin
                phase = 2'd0;
                close_packet(b, 1'b1);
            end
        endcase
        return 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got,
                                logic [31:0] pkt);
        if (want !== got)
        begin
            errors++;
            if (errors < 40)
            begin
                $display("%0t: packet %0d %s expected %0h actual %0h",
                         $time, pkt, name, want, got);
            end
        end
    endfunction

    function void check_report(mouse_report_t got);
        mouse_report_t want;
        reports_seen++;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors < 40)
            begin
                $display("%0t: unexpected report, expected none, actual total %0d",
                         $time, got.packet_total);
            end
            return;
        end
        want = expected_q.pop_front();
        compare_field("cursor_x", want.cursor_x, got.cursor_x, want.packet_total);
        compare_field("cursor_y", want.cursor_y, got.cursor_y, want.packet_total);
        compare_field("text_col", want.text_col, got.text_col, want.packet_total);
        compare_field("text_row", want.text_row, got.text_row, want.packet_total);
        compare_field("move_x", want.move_x, got.move_x, want.packet_total);
        compare_field("move_y", want.move_y, got.move_y, want.packet_total);
        compare_field("wheel_step", want.wheel_step, got.wheel_step, want.packet_total);
        compare_field("scroll_total", want.scroll_total, got.scroll_total,
                      want.packet_total);
        compare_field("button_bits", want.button_bits, got.button_bits, want.packet_total);
        compare_field("packet_total", want.packet_total, got.packet_total,
                      want.packet_total);
    endfunction
endclass

module ps2_mouse_packet_tracker_top_test;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [1:0]         cfg_index = 2'd0;
    logic [12:0]        cfg_data  = 13'd0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte   = 8'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [11:0]        cursor_x;
    logic [11:0]        cursor_y;
    logic [6:0]         text_col;
    logic [4:0]         text_row;
    logic signed [8:0]  move_x;
    logic signed [9:0]  move_y;
    logic signed [4:0]  wheel_step;
    logic signed [31:0] scroll_total;
    logic [2:0]         button_bits;
    logic [31:0]        packet_total;

    mouse_report_board board = new();
    mouse_report_t     seen;
    int                in_gap_pct    = 0;
    int                out_stall_pct = 0;
    int                stall_left    = 0;
    int                bytes_taken   = 0;
    int                cfg_writes    = 0;

    ps2_mouse_packet_tracker_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .text_col     (text_col),
        .text_row     (text_row),
        .move_x       (move_x),
        .move_y       (move_y),
        .wheel_step   (wheel_step),
        .scroll_total (scroll_total),
        .button_bits  (button_bits),
        .packet_total (packet_total)
    );

    always #5 clk = ~clk;

    // receiver side: random stall bursts on out_ready, their chance set by out_stall_pct
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.cursor_x     = cursor_x;
            seen.cursor_y     = cursor_y;
            seen.text_col     = text_col;
            seen.text_row     = text_row;
            seen.move_x       = move_x;
            seen.move_y       = move_y;
            seen.wheel_step   = wheel_step;
            seen.scroll_total = scroll_total;
            seen.button_bits  = button_bits;
            seen.packet_total = packet_total;
            board.check_report(seen);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        if (board.note_byte(b))
        begin
            bytes_taken++;
        end
    endtask

    // writes all three registers once the block has drained
    task automatic write_regs(input logic [1:0] mode, input logic [12:0] w,
                              input logic [12:0] h);
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WHEEL_MODE;
        cfg_data  <= {11'd0, mode};
        @(posedge clk);
        board.set_reg(REG_WHEEL_MODE, {11'd0, mode});
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        board.set_reg(REG_SCREEN_WIDTH, w);
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        board.set_reg(REG_SCREEN_HEIGHT, h);
        cfg_we <= 1'b0;
        cfg_writes += 3;
    endtask

    task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2);
        send_byte(b0);
        send_byte(b1);
        send_byte(b2);
    endtask

    function automatic logic [12:0] pick_bound();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd4096;
            3:       return 13'd8191;
            4:       return 13'($urandom_range(4097, 8191));
            5:       return 13'($urandom_range(1, 16));
            default: return 13'($urandom_range(17, 4096));
        endcase
    endfunction

    function automatic logic [7:0] pick_move();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'(8'h80 - $urandom_range(0, 1));
            3, 4:    return 8'($urandom_range(0, 7));
            5:       return 8'($urandom_range(248, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_wheel();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 8));
            1:       return 8'($urandom_range(248, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed packets; some noise, bad headers and cut-off packets
    task automatic send_random();
        int          kind;
        logic [7:0]  h;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            send_byte(8'($urandom_range(0, 255)));
            return;
        end
        // close any open packet with random filler so framing lines up again
        while (board.phase != 2'd0) send_byte(8'($urandom_range(0, 255)));
        h    = 8'($urandom_range(0, 255));
        h[3] = 1'b1;
        if ($urandom_range(0, 19) != 0)
        begin
            h[7:6] = 2'b00;
        end
        send_byte(h);
        if (kind < 13)
        begin
            return;
        end
        send_byte(pick_move());
        send_byte(pick_move());
        if (board.four_byte_mode())
        begin
            send_byte(pick_wheel());
        end
    endtask

    initial
    begin
        int goal;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset bounds, no wheel: dropped non-headers, sign and button extremes
        send_byte(8'h00);
        send_byte(8'hC8);
        send_byte(8'h48);
        send_packet(8'h3F, 8'h00, 8'h00);
        send_packet(8'h08, 8'hFF, 8'hFF);

        // signed-byte wheel at both ends of -8..8 and past it; zero and oversize bounds
        write_regs(MODE_BYTE, 13'd0, 13'd8191);
        send_packet(8'h08, 8'h01, 8'h01);
        send_byte(8'h08);
        send_packet(8'h0A, 8'h00, 8'h00);
        send_byte(8'hF8);
        send_packet(8'h0C, 8'h7F, 8'h80);
        send_byte(8'h7F);

        // nibble wheel, then a mode change while the fourth byte is outstanding
        write_regs(MODE_NIBBLE, 13'd4096, 13'd1);
        send_packet(8'h08, 8'h00, 8'h00);
        send_byte(8'h07);
        send_packet(8'h09, 8'h10, 8'hF0);
        write_regs(MODE_UNUSED, 13'd4096, 13'd1);
        send_byte(8'h05);
        send_packet(8'h28, 8'h05, 8'h80);

        for (int ph = 0; ph < 12; ph++)
        begin
            write_regs(2'($urandom_range(0, 3)), pick_bound(), pick_bound());
            if (ph >= 10)
            begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end
            else
            begin
                in_gap_pct    = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
                out_stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(5, 40);
            end
            goal = bytes_taken + 145;
            while (bytes_taken < goal) send_random();
        end

        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("covered %0d bytes framed into %0d packet reports, %0d register writes",
                 bytes_taken, board.reports_seen, cfg_writes);
        $display("modes 0-3, bounds from zero past 4096, wheel and clamp extremes");
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d reports outstanding", board.pending());
        $display("tb: failure");
        $finish;
    end

endmodule
